### hw/rtl/ced_pkg.sv
// package for the caret escape decoder
// character codes, escape modes and the request record passed from front to back
// no dependencies
package ced_pkg;

  localparam int CED_QUEUE_DEPTH = 2;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

  localparam logic [7:0] CH_TICK       = 8'h60;
  localparam logic [7:0] CH_CARET      = 8'h5E;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // second pending digit means the next digit completes the escape
  localparam logic [1:0] DIGITS_LAST_PENDING = 2'd2;

  localparam int         ADDR_W           = 3;
  localparam int         DATA_W           = 32;
  localparam logic       REG_MAX_LENGTH   = 1'b0;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_CARET  = 2'd2,
    MODE_DIGITS = 2'd3
  } mode_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_val;
    logic       is_count;
  } res_t;

  // one decoded request: up to two results, slot0 first
  typedef struct packed {
    res_t slot0;
    res_t slot1;
  } job_t;

endpackage

### hw/rtl/ced_front.sv
// front end: accepts characters, tracks the escape state and capacity
// builds one request of up to two results per item; uses ced_pkg
module ced_front
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_string,
  input  logic [7:0] max_length,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [7:0] written_r, written_nxt;

  logic       accept;
  logic       is_quoted, is_ctrl, is_dig;
  logic       plain_v;
  logic [7:0] plain_b;
  mode_t      plain_mode;
  logic [7:0] dig_new;

  logic       c0_v, c1_v;
  logic [7:0] c0, c1;
  logic       k0, k1;
  logic [7:0] bw1, bw2;

  assign accept    = in_valid && !q_full;
  assign is_quoted = in_char_in inside {CH_TICK, CH_CARET, CH_BAR};
  assign is_ctrl   = in_char_in inside {[CH_AT:CH_UNDERSCORE]};
  assign is_dig    = in_char_in inside {[CH_ZERO:CH_NINE]};
  assign plain_v   = !(in_char_in == CH_TICK || in_char_in == CH_CARET);
  assign plain_b   = (in_char_in == CH_BAR) ? CH_CR : in_char_in;
  assign plain_mode = (in_char_in == CH_TICK)  ? MODE_TICK :
                      (in_char_in == CH_CARET) ? MODE_CARET : MODE_PLAIN;
  // value * 10 + digit, wrapping at 8 bits
  assign dig_new   = {digit_r[4:0], 3'b000} + {digit_r[6:0], 1'b0} + {4'b0000, in_char_in[3:0]};

  // candidate bytes
  always_comb begin
    c0_v = 1'b0;
    c0   = '0;
    c1_v = 1'b0;
    c1   = '0;
    if (in_end_of_string) begin
      case (mode_r)
        MODE_TICK: begin
          c0_v = 1'b1;
          c0   = CH_TICK;
        end
        MODE_CARET: begin
          c0_v = 1'b1;
          c0   = CH_CARET;
        end
        MODE_DIGITS: begin
          c0_v = 1'b1;
          c0   = digit_r;
        end
        default: ;
      endcase
    end else begin
      case (mode_r)
        MODE_TICK: begin
          c0_v = 1'b1;
          if (is_quoted) begin
            c0 = in_char_in;
          end else begin
            c0   = CH_TICK;
            c1_v = plain_v;
            c1   = plain_b;
          end
        end
        MODE_CARET: begin
          if (is_ctrl) begin
            c0_v = 1'b1;
            c0   = in_char_in - CH_AT;
          end else if (!is_dig) begin
            c0_v = 1'b1;
            c0   = CH_CARET;
            c1_v = plain_v;
            c1   = plain_b;
          end
        end
        MODE_DIGITS: begin
          if (is_dig) begin
            c0_v = (seen_r == DIGITS_LAST_PENDING);
            c0   = dig_new;
          end else begin
            c0_v = 1'b1;
            c0   = digit_r;
            c1_v = plain_v;
            c1   = plain_b;
          end
        end
        default: begin
          c0_v = plain_v;
          c0   = plain_b;
        end
      endcase
    end
  end

  // capacity check, the second byte can only pass if the first did
  assign k0  = c0_v && (written_r < max_length);
  assign bw1 = written_r + {7'd0, k0};
  assign k1  = c1_v && (bw1 < max_length);
  assign bw2 = bw1 + {7'd0, k1};

  always_comb begin
    push_job.slot0.valid    = k0 || in_end_of_string;
    push_job.slot0.byte_val = k0 ? c0 : bw2;
    push_job.slot0.is_count = !k0;
    push_job.slot1.valid    = k1 || (k0 && in_end_of_string);
    push_job.slot1.byte_val = k1 ? c1 : bw2;
    push_job.slot1.is_count = !k1;
    push = accept && push_job.slot0.valid;
  end

  // escape state
  always_comb begin
    mode_nxt    = mode_r;
    digit_nxt   = digit_r;
    seen_nxt    = seen_r;
    written_nxt = written_r;
    if (accept) begin
      if (in_end_of_string) begin
        mode_nxt    = MODE_PLAIN;
        digit_nxt   = '0;
        seen_nxt    = '0;
        written_nxt = '0;
      end else begin
        written_nxt = bw2;
        case (mode_r)
          MODE_TICK: begin
            mode_nxt = is_quoted ? MODE_PLAIN : plain_mode;
          end
          MODE_CARET: begin
            if (is_ctrl) begin
              mode_nxt = MODE_PLAIN;
            end else if (is_dig) begin
              mode_nxt  = MODE_DIGITS;
              digit_nxt = {4'b0000, in_char_in[3:0]};
              seen_nxt  = 2'd1;
            end else begin
              mode_nxt = plain_mode;
            end
          end
          MODE_DIGITS: begin
            if (is_dig && seen_r != DIGITS_LAST_PENDING) begin
              digit_nxt = dig_new;
              seen_nxt  = seen_r + 2'd1;
            end else begin
              mode_nxt  = is_dig ? MODE_PLAIN : plain_mode;
              digit_nxt = '0;
              seen_nxt  = '0;
            end
          end
          default: begin
            mode_nxt = plain_mode;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      digit_r   <= '0;
      seen_r    <= '0;
      written_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      digit_r   <= digit_nxt;
      seen_r    <= seen_nxt;
      written_r <= written_nxt;
    end
  end

  a_digits_pending : assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DIGITS |-> (seen_r == 2'd1 || seen_r == 2'd2))
    else $error("digit escape pending with bad digit count");

endmodule

### hw/rtl/ced_queue.sv
// request queue between front and back
// small circular buffer of job_t records; uses ced_pkg
module ced_queue
  import ced_pkg::*;
#(
  parameter int DEPTH = CED_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_job   = entry_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("request queue read while empty");

endmodule

### hw/rtl/ced_back.sv
// back end: drains queued requests into the output register, one result per cycle
// while out_stall is low; uses ced_pkg
module ced_back
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_is_count,
  output logic       out_last
);

  logic       sel_r, sel_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       count_r;
  logic       load;
  res_t       cur;

  assign load = head_valid && (!valid_r || !out_stall);
  assign cur  = sel_r ? head_job.slot1 : head_job.slot0;
  assign pop  = load && (sel_r || !head_job.slot1.valid);

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      sel_nxt   = !pop;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= cur.byte_val;
      count_r <= cur.is_count;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte_out = byte_r;
  assign out_is_count = count_r;
  assign out_last     = count_r;

  a_second_slot : assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (head_valid && head_job.slot1.valid))
    else $error("second result selected without a pending second slot");

endmodule

### hw/rtl/caret_escape_decoder_unit.sv
// caret escape decoder, top level: front, request queue, back and register port
// depends on ced_pkg, ced_front, ced_queue, ced_back
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_char_in, in_end_of_string
//   out_     output     out_valid/out_stall  out_byte_out, out_is_count, out_last
//   cfg      input      psel/penable/pready  paddr, pwdata, prdata (max_length)
//
// one character accepted per cycle while the request queue has room
// one result per cycle leaves the output register while out_stall is low, slot0
// first; requests are registered in the queue, then results in the output register
// synchronous active-low reset clears the escape state and queue, max_length to 255
// out_stall holds the output register; in_stall rises only when the queue is full
module caret_escape_decoder_unit
  import ced_pkg::*;
#(
  parameter int QUEUE_DEPTH = CED_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_in,
  input  logic              in_end_of_string,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte_out,
  output logic              out_is_count,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [7:0] max_length_r;
  logic       q_full;
  logic       push;
  job_t       push_job;
  logic       pop;
  logic       head_valid;
  job_t       head_job;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LENGTH) begin
      max_length_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {{(DATA_W-8){1'b0}}, max_length_r} : '0;

  assign in_stall = q_full;

  ced_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_char_in      (in_char_in),
    .in_end_of_string(in_end_of_string),
    .max_length      (max_length_r),
    .q_full          (q_full),
    .push            (push),
    .push_job        (push_job)
  );

  ced_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  ced_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte_out(out_byte_out),
    .out_is_count(out_is_count),
    .out_last    (out_last)
  );

endmodule

### bench/testbench.sv
// self-checking bench for caret_escape_decoder_unit: directed table, then random escaped strings
// every request is decoded by an in-bench predictor and each result is checked in order
// depends on ced_pkg and caret_escape_decoder_unit
module testbench;
  import ced_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PREDICT = -1;
  localparam int NUM_PHASES = 7;
  localparam logic [ADDR_W-1:0] MAX_LENGTH_ADDR = ADDR_W'(4 * int'(REG_MAX_LENGTH));

  typedef struct packed {
    logic [7:0] value;
    logic       is_count;
    logic       last;
  } decoded_t;

  localparam decoded_t NO_RES = '0;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    int         nres;
    decoded_t   r0;
    decoded_t   r1;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_in;
  logic              in_end_of_string;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte_out;
  logic              out_is_count;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  caret_escape_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_is_count     (out_is_count),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // predictor state
  logic [7:0] max_len_cfg;
  mode_t      esc_mode;
  logic [7:0] num_value;
  logic [1:0] num_digits;
  logic [7:0] bytes_kept;
  decoded_t   step_bytes[$];
  decoded_t   expected_bytes[$];

  int  errors;
  int  requests_sent;
  int  strings_done;
  int  results_checked;
  int  cycles;
  bit  sender_gaps;
  bit  receiver_stalls;
  int  stall_left;

  function automatic void keep_byte(input logic [7:0] b);
    if (bytes_kept < max_len_cfg) begin
      step_bytes.push_back({b, 2'b00});
      bytes_kept = bytes_kept + 8'd1;
    end
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void decode_plain(input logic [7:0] c);
    if (c == CH_TICK) begin
      esc_mode = MODE_TICK;
    end else if (c == CH_CARET) begin
      esc_mode = MODE_CARET;
    end else if (c == CH_BAR) begin
      keep_byte(CH_CR);
    end else begin
      keep_byte(c);
    end
  endfunction

  function automatic void clear_number();
    num_value = 8'd0;
    num_digits = 2'd0;
  endfunction

  // decode one request into step_bytes and advance the escape state
  function automatic void decode_request(input logic [7:0] c, input logic eos);
    mode_t m;
    m = esc_mode;
    step_bytes.delete();
    if (eos) begin
      case (m)
        MODE_TICK:   keep_byte(CH_TICK);
        MODE_CARET:  keep_byte(CH_CARET);
        MODE_DIGITS: keep_byte(num_value);
        default: ;
      endcase
      step_bytes.push_back({bytes_kept, 2'b11});
      esc_mode = MODE_PLAIN;
      clear_number();
      bytes_kept = 8'd0;
      return;
    end
    esc_mode = MODE_PLAIN;
    case (m)
      MODE_TICK: begin
        if (c == CH_CARET || c == CH_TICK || c == CH_BAR) begin
          keep_byte(c);
        end else begin
          keep_byte(CH_TICK);
          decode_plain(c);
        end
      end
      MODE_CARET: begin
        if (c >= CH_AT && c <= CH_UNDERSCORE) begin
          keep_byte(8'(c - CH_AT));
        end else if (is_digit(c)) begin
          num_value = 8'(c - CH_ZERO);
          num_digits = 2'd1;
          esc_mode = MODE_DIGITS;
        end else begin
          keep_byte(CH_CARET);
          decode_plain(c);
        end
      end
      MODE_DIGITS: begin
        if (is_digit(c)) begin
          num_value = 8'(num_value * 8'd10 + 8'(c - CH_ZERO));
          num_digits = num_digits + 2'd1;
          if (num_digits == 2'd3 || num_digits == 2'd0) begin
            keep_byte(num_value);
            clear_number();
          end else begin
            esc_mode = MODE_DIGITS;
          end
        end else begin
          keep_byte(num_value);
          clear_number();
          decode_plain(c);
        end
      end
      default: decode_plain(c);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             expected_bytes.size());
    $display("FAILURE");
    $finish;
  end

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte %02h count %0b last %0b", $time,
                 out_byte_out, out_is_count, out_last);
      end else begin
        want = expected_bytes.pop_front();
        results_checked++;
        if (out_byte_out !== want.value) begin
          errors++;
          $display("%0t: byte_out expected %02h got %02h", $time, want.value, out_byte_out);
        end
        if (out_is_count !== want.is_count) begin
          errors++;
          $display("%0t: is_count expected %0b got %0b", $time, want.is_count, out_is_count);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(6, 30);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input logic [7:0] c, input logic eos, input int nres = PREDICT,
                              input decoded_t r0 = NO_RES, input decoded_t r1 = NO_RES);
    int r;
    int gap;
    gap = 0;
    if (sender_gaps) begin
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (eos) strings_done++;
    decode_request(c, eos);
    if (nres == PREDICT) begin
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    end else begin
      if (nres > 0) expected_bytes.push_back(r0);
      if (nres > 1) expected_bytes.push_back(r1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic set_max_length(input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_LENGTH_ADDR;
    pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_len_cfg = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      errors++;
      $display("%0t: max_length read expected %02h got %02h", $time, v, prdata[7:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // one well-formed escape, a lone special, a plain byte, or end of string
  task automatic send_token(input int eos_per_mille);
    int kind;
    int r;
    if ($urandom_range(0, 999) < eos_per_mille) begin
      send_request(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    kind = $urandom_range(0, 15);
    case (kind)
      0, 1: begin
        send_request(CH_TICK, 1'b0);
        r = $urandom_range(0, 3);
        send_request(r == 0 ? CH_CARET : r == 1 ? CH_TICK : r == 2 ? CH_BAR :
                     8'($urandom_range(0, 255)), 1'b0);
      end
      2, 3, 4: begin
        send_request(CH_CARET, 1'b0);
        send_request(8'($urandom_range(CH_AT, CH_UNDERSCORE)), 1'b0);
      end
      5, 6, 7: begin
        send_request(CH_CARET, 1'b0);
        repeat ($urandom_range(1, 3)) send_request(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      end
      8: begin
        r = $urandom_range(0, 2);
        send_request(r == 0 ? CH_TICK : r == 1 ? CH_CARET : CH_BAR, 1'b0);
      end
      9, 10: send_request(8'($urandom_range(0, 255)), 1'b0);
      default: send_request(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    endcase
  endtask

  initial begin
    stim_row_t directed[25];
    logic [7:0] phase_len[NUM_PHASES];
    int phase_items[NUM_PHASES];
    int phase_end;
    int eos_pm;

    directed = '{
      '{8'h00, 1'b1, 1, {8'h00, 2'b11}, NO_RES},
      '{8'h00, 1'b0, 1, {8'h00, 2'b00}, NO_RES},
      '{8'hFF, 1'b0, 1, {8'hFF, 2'b00}, NO_RES},
      '{CH_BAR, 1'b0, 1, {CH_CR, 2'b00}, NO_RES},
      '{CH_TICK, 1'b0, 0, NO_RES, NO_RES},
      '{CH_BAR, 1'b0, 1, {CH_BAR, 2'b00}, NO_RES},
      '{CH_TICK, 1'b0, 0, NO_RES, NO_RES},
      '{8'h41, 1'b0, 2, {CH_TICK, 2'b00}, {8'h41, 2'b00}},
      '{CH_CARET, 1'b0, 0, NO_RES, NO_RES},
      '{CH_AT, 1'b0, 1, {8'h00, 2'b00}, NO_RES},
      '{CH_CARET, 1'b0, 0, NO_RES, NO_RES},
      '{CH_UNDERSCORE, 1'b0, 1, {8'h1F, 2'b00}, NO_RES},
      '{CH_CARET, 1'b0, 0, NO_RES, NO_RES},
      '{8'h32, 1'b0, 0, NO_RES, NO_RES},
      '{8'h35, 1'b0, 0, NO_RES, NO_RES},
      '{8'h35, 1'b0, 1, {8'hFF, 2'b00}, NO_RES},
      '{CH_CARET, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h39, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h39, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h78, 1'b0, PREDICT, NO_RES, NO_RES},
      '{CH_CARET, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h61, 1'b0, PREDICT, NO_RES, NO_RES},
      '{CH_CARET, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h34, 1'b0, PREDICT, NO_RES, NO_RES},
      '{8'h00, 1'b1, PREDICT, NO_RES, NO_RES}
    };
    phase_len = '{8'd0, 8'd1, 8'd3, 8'd17, 8'd128, 8'd255, 8'($urandom_range(0, 255))};
    phase_items = '{150, 150, 200, 200, 225, 400, 200};

    errors = 0;
    requests_sent = 0;
    strings_done = 0;
    results_checked = 0;
    stall_left = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    max_len_cfg = MAX_LENGTH_RESET;
    esc_mode = MODE_PLAIN;
    clear_number();
    bytes_kept = 8'd0;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_in <= 8'h00;
    in_end_of_string <= 1'b0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i].ch, directed[i].eos, directed[i].nres, directed[i].r0,
                   directed[i].r1);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_max_length(phase_len[p]);
      sender_gaps = (p != 2 && p != 4);
      receiver_stalls = (p != 3 && p != 4);
      // long strings at full capacity so the count saturates
      eos_pm = (phase_len[p] == 8'd255) ? 2 : 60;
      phase_end = requests_sent + phase_items[p];
      while (requests_sent < phase_end) begin
        send_token(eos_pm);
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end
    send_request(8'h00, 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_bytes.size());
    end

    $display("%0d requests in %0d strings decoded, %0d results checked", requests_sent,
             strings_done, results_checked);
    $display("%0d max_length settings from 0 to 255, %0d errors", NUM_PHASES, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ced_pkg.sv
hw/rtl/ced_front.sv
hw/rtl/ced_queue.sv
hw/rtl/ced_back.sv
hw/rtl/caret_escape_decoder_unit.sv
bench/testbench.sv
